>>> rtl/lcdf_pkg.sv
// shared constants, job descriptor and character helpers for the lcd command formatter
`timescale 1ns / 1ps

package lcdf_pkg;

   localparam int MAX_DIGITS_DEF = 10;
   localparam int ROWS           = 4;
   localparam int COLUMNS        = 20;
   localparam int QUEUE_DEPTH    = 2;

   // byte counts per request: a cursor byte plus up to ten digits (MAX_DIGITS_DEF)
   localparam int LEN_W = 5;

   localparam logic [2:0] ACT_INSTR  = 3'd0;
   localparam logic [2:0] ACT_DATA   = 3'd1;
   localparam logic [2:0] ACT_CURSOR = 3'd2;
   localparam logic [2:0] ACT_DEC    = 3'd3;
   localparam logic [2:0] ACT_HEX    = 3'd4;
   localparam logic [2:0] ACT_BIN    = 3'd5;

   localparam logic [1:0] FMT_RAW = 2'd0;
   localparam logic [1:0] FMT_DEC = 2'd1;
   localparam logic [1:0] FMT_HEX = 2'd2;
   localparam logic [1:0] FMT_BIN = 2'd3;

   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_HEX_ALPHA = 8'h37;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_B         = 8'h62;

   localparam logic [LEN_W-1:0] HEX_LEN = 5'd4;
   localparam logic [LEN_W-1:0] BIN_LEN = 5'd9;

   // v / 10 == (v * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit v
   localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;

   typedef struct packed {
      logic             cursor;
      logic [7:0]       cursor_byte;
      logic [1:0]       fmt;
      logic             rs;
      logic [7:0]       data;
      logic [LEN_W-1:0] total;
   } job_type;

   function automatic logic [7:0] row_base(input logic [1:0] idx);
      logic [7:0] base;
      unique case (idx)
         2'd0: base = 8'h80;
         2'd1: base = 8'hC0;
         2'd2: base = 8'h94;
         2'd3: base = 8'hD4;
      endcase
      return base;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib > 4'd9) ? (CH_HEX_ALPHA + {4'b0000, nib}) : (CH_ZERO + {4'b0000, nib});
   endfunction

endpackage

>>> rtl/lcdf_front.sv
// front end: accepts requests, builds a job and converts decimal digits
`timescale 1ns / 1ps

module lcdf_front #(
   parameter int MAX_DIGITS = lcdf_pkg::MAX_DIGITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_action,
   input  logic [7:0]                req_code,
   input  logic [2:0]                req_row,
   input  logic [4:0]                req_column,
   input  logic                      req_place_first,
   input  logic [31:0]               req_number,
   input  logic [3:0]                req_digit_count,
   output logic                      push,
   output lcdf_pkg::job_type         push_job,
   output logic [MAX_DIGITS*4-1:0]   push_digits,
   input  logic                      q_full
);
   import lcdf_pkg::*;

   localparam int DIG_W = MAX_DIGITS * 4;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CONV = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   job_type          job_ff, job_in, job_new;
   logic [DIG_W-1:0] digits_ff, digits_in;
   logic [31:0]      value_ff, value_in;
   logic [LEN_W-1:0] steps_ff, steps_in;

   logic             cur_ok;
   logic [7:0]       cur_byte;
   logic [LEN_W-1:0] dcount, body_len;
   logic [63:0]      prod;
   logic [31:0]      quot;
   logic [3:0]       rem;

   // one digit per cycle: quotient by reciprocal, remainder from the low nibble only
   assign prod = 64'(value_ff) * 64'(DIV10_MAGIC);
   assign quot = 32'(prod >> DIV10_SHIFT);
   assign rem  = value_ff[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};

   assign cur_ok = (req_row != 3'd0) && (32'(req_row) <= ROWS) &&
                   (req_column != 5'd0) && (32'(req_column) <= COLUMNS);
   assign cur_byte = row_base(2'(req_row - 3'd1)) + {3'b000, 5'(req_column - 5'd1)};
   assign dcount = (32'(req_digit_count) > MAX_DIGITS) ? LEN_W'(MAX_DIGITS)
                                                        : LEN_W'(req_digit_count);

   always_comb begin
      job_new             = '0;
      job_new.cursor_byte = cur_byte;
      job_new.fmt         = FMT_RAW;
      body_len            = '0;
      unique case (req_action)
         ACT_INSTR: begin
            job_new.data = req_code;
            body_len     = LEN_W'(1);
         end
         ACT_DATA: begin
            job_new.rs   = 1'b1;
            job_new.data = req_code;
            body_len     = LEN_W'(1);
         end
         ACT_CURSOR: begin
            job_new.cursor = cur_ok;
         end
         ACT_DEC: begin
            job_new.cursor = req_place_first && cur_ok;
            job_new.fmt    = FMT_DEC;
            body_len       = dcount;
         end
         ACT_HEX: begin
            job_new.cursor = req_place_first && cur_ok;
            job_new.fmt    = FMT_HEX;
            job_new.data   = req_number[7:0];
            body_len       = HEX_LEN;
         end
         ACT_BIN: begin
            job_new.cursor = req_place_first && cur_ok;
            job_new.fmt    = FMT_BIN;
            job_new.data   = req_number[7:0];
            body_len       = BIN_LEN;
         end
         default: begin
            body_len = '0;
         end
      endcase
      job_new.total = LEN_W'(job_new.cursor) + body_len;
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      value_in  = value_ff;
      digits_in = digits_ff;
      steps_in  = steps_ff;
      push      = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               job_in    = job_new;
               value_in  = req_number;
               digits_in = '0;
               steps_in  = dcount;
               state_in  = (req_action == ACT_DEC && dcount != '0) ? F_CONV : F_PUSH;
            end
         end
         F_CONV: begin
            value_in  = quot;
            // newest digit lands low so the most significant shown digit ends at the bottom
            digits_in = (digits_ff << 4) | DIG_W'(rem);
            steps_in  = LEN_W'(steps_ff - LEN_W'(1));
            if (steps_ff == LEN_W'(1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ff.total == '0) begin
               state_in = F_IDLE;
            end else if (!q_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      value_ff  <= value_in;
      digits_ff <= digits_in;
      steps_ff  <= steps_in;
   end

   assign req_ready   = (state_ff == F_IDLE);
   assign push_job    = job_ff;
   assign push_digits = digits_ff;

endmodule

>>> rtl/lcdf_queue.sv
// short job queue between the front end and the byte sequencer
`timescale 1ns / 1ps

module lcdf_queue #(
   parameter int DIG_W = lcdf_pkg::MAX_DIGITS_DEF * 4,
   parameter int DEPTH = lcdf_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcdf_pkg::job_type push_job,
   input  logic [DIG_W-1:0]  push_digits,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output lcdf_pkg::job_type pop_job,
   output logic [DIG_W-1:0]  pop_digits
);
   import lcdf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          job_mem_ff [DEPTH];
   logic [DIG_W-1:0] dig_mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         job_mem_ff[wr_ptr_ff] <= push_job;
         dig_mem_ff[wr_ptr_ff] <= push_digits;
      end
   end

   assign pop_job    = job_mem_ff[rd_ptr_ff];
   assign pop_digits = dig_mem_ff[rd_ptr_ff];

endmodule

>>> rtl/lcdf_back.sv
// back end: walks one job byte by byte into the output register
`timescale 1ns / 1ps

module lcdf_back #(
   parameter int MAX_DIGITS = lcdf_pkg::MAX_DIGITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    pop,
   input  lcdf_pkg::job_type       q_job,
   input  logic [MAX_DIGITS*4-1:0] q_digits,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_reg_select,
   output logic [7:0]              rsp_bus_byte,
   output logic                    rsp_last
);
   import lcdf_pkg::*;

   localparam int DIG_W = MAX_DIGITS * 4;

   logic             busy_ff, busy_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   job_type          job_ff, job_in;
   logic [DIG_W-1:0] digits_ff, digits_in;
   logic [7:0]       bits_ff, bits_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_rs_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   logic             advance, shift_dig, shift_bit, out_rs, out_last;
   logic [7:0]       out_byte;
   logic [LEN_W-1:0] k;

   assign pop      = !busy_ff && q_valid;
   assign advance  = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign k        = LEN_W'(pos_ff - LEN_W'(job_ff.cursor));
   assign out_last = (pos_ff == LEN_W'(job_ff.total - LEN_W'(1)));

   always_comb begin
      out_rs    = 1'b1;
      out_byte  = CH_ZERO;
      shift_dig = 1'b0;
      shift_bit = 1'b0;
      if (job_ff.cursor && pos_ff == '0) begin
         out_rs   = 1'b0;
         out_byte = job_ff.cursor_byte;
      end else begin
         unique case (job_ff.fmt)
            FMT_RAW: begin
               out_rs   = job_ff.rs;
               out_byte = job_ff.data;
            end
            FMT_DEC: begin
               out_byte  = CH_ZERO + {4'b0000, digits_ff[3:0]};
               shift_dig = 1'b1;
            end
            FMT_HEX: begin
               if (k == LEN_W'(0)) begin
                  out_byte = CH_ZERO;
               end else if (k == LEN_W'(1)) begin
                  out_byte = CH_X;
               end else if (k == LEN_W'(2)) begin
                  out_byte = hex_char(job_ff.data[7:4]);
               end else begin
                  out_byte = hex_char(job_ff.data[3:0]);
               end
            end
            FMT_BIN: begin
               if (k == LEN_W'(BIN_LEN - LEN_W'(1))) begin
                  out_byte = CH_B;
               end else begin
                  out_byte  = CH_ZERO + {7'b0000000, bits_ff[7]};
                  shift_bit = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      pos_in    = pos_ff;
      job_in    = job_ff;
      digits_in = digits_ff;
      bits_in   = bits_ff;
      if (pop) begin
         busy_in   = 1'b1;
         pos_in    = '0;
         job_in    = q_job;
         digits_in = q_digits;
         bits_in   = q_job.data;
      end else if (advance) begin
         pos_in = LEN_W'(pos_ff + LEN_W'(1));
         if (out_last) begin
            busy_in = 1'b0;
         end
         if (shift_dig) begin
            digits_in = digits_ff >> 4;
         end
         if (shift_bit) begin
            bits_in = {bits_ff[6:0], 1'b0};
         end
      end
   end

   // output register frees as soon as the byte is taken
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      job_ff    <= job_in;
      digits_ff <= digits_in;
      bits_ff   <= bits_in;
      if (advance) begin
         rsp_rs_ff   <= out_rs;
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_bus_byte   = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> rtl/char_lcd_command_formatter.sv
// top level of the character lcd command formatter. Each request (raw instruction, raw
// character, cursor placement, fixed-width decimal, hex as 0x plus two digits, binary as
// eight digits plus b) becomes a run of controller bus bytes, each tagged instruction
// (reg_select 0) or data (reg_select 1), with last marking the final byte of the request.
// Requests that yield no bytes (unknown action, invalid cursor alone, zero digits) produce
// nothing on the result channel. Rows 1 to 4 map to 0x80, 0xC0, 0x94, 0xD4 plus column - 1.
// Throughput: the front end holds one request at a time and converts one decimal digit per
// pass of the single divide-by-ten multiplier; the back end sends one byte per cycle while
// the receiver is ready, after loading each job from the queue. A two-entry job queue sits
// between them, so the sustained rate per request is set by the slower of the two.
`timescale 1ns / 1ps

module char_lcd_command_formatter #(
   parameter int MAX_DIGITS = lcdf_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_code,
   input  logic [2:0]  req_row,
   input  logic [4:0]  req_column,
   input  logic        req_place_first,
   input  logic [31:0] req_number,
   input  logic [3:0]  req_digit_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reg_select,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_last
);
   import lcdf_pkg::*;

   localparam int DIG_W = MAX_DIGITS * 4;

   logic             q_push, q_full, q_pop, q_valid;
   job_type          q_job_in, q_job_out;
   logic [DIG_W-1:0] q_digits_in, q_digits_out;

   lcdf_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_code        (req_code),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_place_first (req_place_first),
      .req_number      (req_number),
      .req_digit_count (req_digit_count),
      .push            (q_push),
      .push_job        (q_job_in),
      .push_digits     (q_digits_in),
      .q_full          (q_full)
   );

   lcdf_queue #(
      .DIG_W (DIG_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_job    (q_job_in),
      .push_digits (q_digits_in),
      .full        (q_full),
      .pop         (q_pop),
      .valid       (q_valid),
      .pop_job     (q_job_out),
      .pop_digits  (q_digits_out)
   );

   lcdf_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .pop            (q_pop),
      .q_job          (q_job_out),
      .q_digits       (q_digits_out),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_select (rsp_reg_select),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_last       (rsp_last)
   );

   // the front end holds one request at a time
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while front end was busy");

   // an instruction byte followed by more bytes can only be a cursor address
   a_cursor_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_select && !rsp_last |-> rsp_bus_byte[7])
      else $error("non-final instruction byte is not a ddram address");

   // once a run has started its bytes come without gaps
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a byte run");

endmodule

>>> sim/tb_top.sv
// testbench for the character lcd command formatter: directed, random and backpressure tests
`timescale 1ns / 1ps

module tb_top;
   import lcdf_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   typedef struct {
      logic [2:0]  action;
      logic [7:0]  code;
      logic [2:0]  row;
      logic [4:0]  column;
      logic        place_first;
      logic [31:0] number;
      logic [3:0]  digit_count;
   } lcd_request_type;

   typedef struct packed {
      logic       rs;
      logic [7:0] data;
      logic       last;
   } bus_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_action;
   logic [7:0]  req_code;
   logic [2:0]  req_row;
   logic [4:0]  req_column;
   logic        req_place_first;
   logic [31:0] req_number;
   logic [3:0]  req_digit_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_reg_select;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_last;

   bus_beat_type bus_bytes_expected[$];
   int        sender_idle_pct  = 0;
   int        receiver_stall_pct = 0;
   int        hold_left        = 0;
   int        requests_accepted = 0;
   int        bytes_checked    = 0;
   int        error_count      = 0;

   char_lcd_command_formatter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_code       (req_code),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_place_first(req_place_first),
      .req_number     (req_number),
      .req_digit_count(req_digit_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_select (rsp_reg_select),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected bus bytes for one accepted request
   function automatic void predict_bus_bytes(input lcd_request_type r);
      bus_beat_type run [0:11];
      int          n;
      int          count;
      int          dig [0:9];
      logic [31:0] v;
      logic [7:0]  b;
      logic [7:0]  base;
      logic [3:0]  nib;
      logic        cursor_ok;
      logic [7:0]  cursor_byte;
      n = 0;
      case (r.row)
         3'd1:    base = 8'h80;
         3'd2:    base = 8'hC0;
         3'd3:    base = 8'h94;
         default: base = 8'hD4;
      endcase
      cursor_ok = (r.row >= 1) && (r.row <= ROWS) && (r.column >= 1) && (r.column <= COLUMNS);
      cursor_byte = base + 8'(r.column) - 8'd1;
      b = r.number[7:0];
      case (r.action)
         ACT_INSTR: begin
            run[n] = '{rs: 1'b0, data: r.code, last: 1'b0}; n++;
         end
         ACT_DATA: begin
            run[n] = '{rs: 1'b1, data: r.code, last: 1'b0}; n++;
         end
         ACT_CURSOR: begin
            if (cursor_ok) begin
               run[n] = '{rs: 1'b0, data: cursor_byte, last: 1'b0}; n++;
            end
         end
         ACT_DEC: begin
            count = (r.digit_count > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(r.digit_count);
            if (r.place_first && cursor_ok) begin
               run[n] = '{rs: 1'b0, data: cursor_byte, last: 1'b0}; n++;
            end
            v = r.number;
            for (int i = 0; i < count; i++) begin
               dig[i] = int'(v % 10);
               v = v / 10;
            end
            for (int i = count - 1; i >= 0; i--) begin
               run[n] = '{rs: 1'b1, data: "0" + 8'(dig[i]), last: 1'b0}; n++;
            end
         end
         ACT_HEX: begin
            if (r.place_first && cursor_ok) begin
               run[n] = '{rs: 1'b0, data: cursor_byte, last: 1'b0}; n++;
            end
            run[n] = '{rs: 1'b1, data: "0", last: 1'b0}; n++;
            run[n] = '{rs: 1'b1, data: "x", last: 1'b0}; n++;
            for (int k = 1; k >= 0; k--) begin
               nib = b[k*4 +: 4];
               run[n] = '{rs: 1'b1, data: (nib > 4'd9) ? 8'h37 + nib : 8'h30 + nib,
                          last: 1'b0};
               n++;
            end
         end
         ACT_BIN: begin
            if (r.place_first && cursor_ok) begin
               run[n] = '{rs: 1'b0, data: cursor_byte, last: 1'b0}; n++;
            end
            for (int k = 7; k >= 0; k--) begin
               run[n] = '{rs: 1'b1, data: "0" + 8'(b[k]), last: 1'b0}; n++;
            end
            run[n] = '{rs: 1'b1, data: "b", last: 1'b0}; n++;
         end
         default: ;
      endcase
      for (int i = 0; i < n; i++) begin
         run[i].last = (i == n - 1);
         bus_bytes_expected.push_back(run[i]);
      end
   endfunction

   function automatic lcd_request_type make_request(input logic [2:0] action,
                                                    input logic [7:0] code,
                                                    input logic [2:0] row,
                                                    input logic [4:0] column,
                                                    input logic place_first,
                                                    input logic [31:0] number,
                                                    input logic [3:0] digit_count);
      lcd_request_type r;
      r.action      = action;
      r.code        = code;
      r.row         = row;
      r.column      = column;
      r.place_first = place_first;
      r.number      = number;
      r.digit_count = digit_count;
      return r;
   endfunction

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) r.action = 3'($urandom_range(6, 7));
      else          r.action = 3'($urandom_range(ACT_INSTR, ACT_BIN));
      r.code = 8'($urandom);
      // mostly valid cursor positions, the rest anywhere in the field
      if ($urandom_range(0, 3) != 0) begin
         r.row    = 3'($urandom_range(1, ROWS));
         r.column = 5'($urandom_range(1, COLUMNS));
      end else begin
         r.row    = 3'($urandom);
         r.column = 5'($urandom);
      end
      r.place_first = 1'($urandom);
      case ($urandom_range(0, 3))
         0:       r.number = $urandom_range(0, 999);
         1:       r.number = 32'hFFFF_FFFF;
         2:       r.number = $urandom_range(0, 255);
         default: r.number = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) r.digit_count = 4'($urandom);
      else                           r.digit_count = 4'($urandom_range(0, MAX_DIGITS_DEF));
      return r;
   endfunction

   // drives one request and returns at the edge where it transfers
   task automatic send_request(input lcd_request_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_code        <= r.code;
      req_row         <= r.row;
      req_column      <= r.column;
      req_place_first <= r.place_first;
      req_number      <= r.number;
      req_digit_count <= r.digit_count;
      do @(posedge clock); while (!req_ready);
      predict_bus_bytes(r);
      requests_accepted++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bus_bytes_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(make_request(ACT_INSTR, 8'h00, 3'd0, 5'd0, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_INSTR, 8'hFF, 3'd7, 5'd31, 1'b1, 32'hFFFF_FFFF, 4'd15));
      send_request(make_request(ACT_DATA, 8'h00, 3'd0, 5'd0, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_DATA, 8'hFF, 3'd7, 5'd31, 1'b1, 32'hFFFF_FFFF, 4'd15));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd1, 5'd1, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd2, 5'd20, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd3, 5'd7, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd4, 5'd20, 1'b0, 32'd0, 4'd0));
      // invalid positions give nothing
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd0, 5'd5, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd5, 5'd5, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd7, 5'd31, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd1, 5'd0, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_CURSOR, 8'h00, 3'd2, 5'd21, 1'b0, 32'd0, 4'd0));
      send_request(make_request(ACT_DEC, 8'h00, 3'd1, 5'd1, 1'b1, 32'hFFFF_FFFF, 4'd10));
      send_request(make_request(ACT_DEC, 8'h00, 3'd1, 5'd1, 1'b0, 32'd12345, 4'd0));
      // saturated digit count
      send_request(make_request(ACT_DEC, 8'h00, 3'd3, 5'd10, 1'b1, 32'd1234567890, 4'd15));
      // only the low digits of an overflowing value
      send_request(make_request(ACT_DEC, 8'h00, 3'd1, 5'd1, 1'b0, 32'd98765, 4'd3));
      send_request(make_request(ACT_DEC, 8'h00, 3'd6, 5'd1, 1'b1, 32'd42, 4'd0));
      send_request(make_request(ACT_DEC, 8'h00, 3'd1, 5'd1, 1'b0, 32'd0, 4'd1));
      send_request(make_request(ACT_HEX, 8'h00, 3'd4, 5'd20, 1'b1, 32'h0000_00AB, 4'd0));
      send_request(make_request(ACT_HEX, 8'h00, 3'd1, 5'd1, 1'b0, 32'hFFFF_FF09, 4'd0));
      send_request(make_request(ACT_HEX, 8'h00, 3'd2, 5'd0, 1'b1, 32'h0000_00F0, 4'd0));
      send_request(make_request(ACT_BIN, 8'h00, 3'd2, 5'd1, 1'b1, 32'h0000_005A, 4'd0));
      send_request(make_request(ACT_BIN, 8'h00, 3'd1, 5'd1, 1'b0, 32'h0000_FF00, 4'd0));
      send_request(make_request(3'd6, 8'hFF, 3'd1, 5'd1, 1'b1, 32'hFFFF_FFFF, 4'd10));
      send_request(make_request(3'd7, 8'hFF, 3'd1, 5'd1, 1'b1, 32'hFFFF_FFFF, 4'd10));
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_request(random_request());
   endtask

   // receiver stops for a long stretch while requests keep coming, so the input stalls
   task automatic test_receiver_hold();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_left          = HOLD_CYCLES;
      repeat (12) send_request(random_request());
   endtask

   // sender waits once for all earlier results, between two groups of requests
   task automatic test_sender_pause();
      sender_idle_pct    = 10;
      receiver_stall_pct = 20;
      repeat (6) send_request(random_request());
      wait_drained();
      repeat (6) send_request(random_request());
   endtask

   // receiver readiness, with a counted long hold
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // compares every result transfer with the oldest expected byte
   initial begin
      bus_beat_type seen;
      bus_beat_type want;
      logic      fire;
      forever begin
         @(posedge clock);
         fire = !reset && rsp_valid && rsp_ready;
         seen = '{rs: rsp_reg_select, data: rsp_bus_byte, last: rsp_last};
         #1;
         if (fire) begin
            if (bus_bytes_expected.size() == 0) begin
               $display("%0t: unexpected result rs=%0b byte=%02h last=%0b",
                        $time, seen.rs, seen.data, seen.last);
               error_count++;
            end else begin
               want = bus_bytes_expected.pop_front();
               bytes_checked++;
               if (seen !== want) begin
                  $display({"%0t: mismatch expected rs=%0b byte=%02h last=%0b, ",
                            "got rs=%0b byte=%02h last=%0b"},
                           $time, want.rs, want.data, want.last,
                           seen.rs, seen.data, seen.last);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = '0;
      req_code        = '0;
      req_row         = '0;
      req_column      = '0;
      req_place_first = 1'b0;
      req_number      = '0;
      req_digit_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(28, 0, 0);
      test_random_traffic(28, 63, 0);
      test_random_traffic(28, 0, 63);
      test_random_traffic(28, 38, 38);
      test_receiver_hold();
      test_sender_pause();
      wait_drained();

      if (bus_bytes_expected.size() != 0) error_count++;
      $display("summary: %0d requests accepted, %0d bus bytes checked, %0d errors",
               requests_accepted, bytes_checked, error_count);
      $display("covered raw, cursor, decimal, hex and binary requests under idle, stall and hold");
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
